### sv/mws_pkg.sv
// Shared types, sizes and helper functions of the maximum window sum block.
// Depends on nothing; all other files but mws_ram refer to it by scoped names.
package mws_pkg;

  // Frame limits and the sizes that follow from them.
  localparam int unsigned MAX_ROWS    = 128;
  localparam int unsigned MAX_COLUMNS = 128;
  localparam int unsigned ROW_W       = $clog2(MAX_ROWS);
  localparam int unsigned COL_W       = $clog2(MAX_COLUMNS);

  // Configuration registers are 8 bits wide; CMP_W holds any count or position.
  localparam int unsigned CFG_W     = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned POS_MAX_W = (ROW_W > COL_W) ? ROW_W : COL_W;
  localparam int unsigned CMP_W     = ((CFG_W > POS_MAX_W) ? CFG_W : POS_MAX_W) + 1;

  // Data widths: one element, one column sum over up to MAX_ROWS elements, and the
  // running row sum, kept one bit wider than the result so that saturation is explicit.
  localparam int unsigned ELEM_W  = 16;
  localparam int unsigned SUM_W   = 32;
  localparam int unsigned CS_W    = ELEM_W + ROW_W + 1;
  localparam int unsigned RS_NATW = CS_W + COL_W;
  localparam int unsigned ACC_W   = ((RS_NATW > SUM_W) ? RS_NATW : SUM_W) + 1;

  localparam int unsigned LINE_AW    = ROW_W + COL_W;
  localparam int unsigned LINE_DEPTH = MAX_ROWS * (2 ** COL_W);

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);

  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_COUNT     = 2'd0,
    CFG_COLUMN_COUNT  = 2'd1,
    CFG_WINDOW_WIDTH  = 2'd2,
    CFG_WINDOW_HEIGHT = 2'd3
  } cfg_reg_e;

  // One classified element on its way from the front end to the datapath.
  typedef struct packed {
    logic signed [ELEM_W-1:0] element;
    logic [COL_W-1:0]         col;
    logic [LINE_AW-1:0]       line_waddr;
    logic [LINE_AW-1:0]       line_raddr;
    logic [COL_W-1:0]         hist_raddr;
    logic                     first_row;
    logic                     sub_line;
    logic                     col0;
    logic                     sub_hist;
    logic                     win;
    logic                     last;
  } cmd_t;

  // A count of zero acts as one and a count above the limit acts as the limit.
  function automatic logic [CMP_W-1:0] clamp_count(input logic [CFG_W-1:0] v,
                                                   input int unsigned lim);
    logic [CMP_W-1:0] ext;
    logic [CMP_W-1:0] top;
    ext = CMP_W'(v);
    top = CMP_W'(lim);
    if (ext == '0) begin
      return CMP_W'(1);
    end
    return (ext > top) ? top : ext;
  endfunction

  function automatic logic [CMP_W-1:0] window_size(input logic [CFG_W-1:0] v);
    return (v == '0) ? CMP_W'(1) : CMP_W'(v);
  endfunction

  function automatic logic [SUM_W-1:0] sat_sum(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = {{(ACC_W-SUM_W){1'b0}}, SUM_MAX};
    lo = {{(ACC_W-SUM_W){1'b1}}, SUM_MIN};
    if (v > hi) begin
      return SUM_MAX;
    end
    if (v < lo) begin
      return SUM_MIN;
    end
    return v[SUM_W-1:0];
  endfunction

endpackage

### sv/mws_ram.sv
// Generic simple dual-port RAM: one write port and one registered read port.
// Depends on nothing; a read in the cycle of a write to the same address returns old data.
module mws_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/mws_front.sv
// Front end: configuration registers, frame position counters and classification
// of each element into a command for the datapath. Depends on mws_pkg.
module mws_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [mws_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mws_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [mws_pkg::ELEM_W-1:0]  element_i,
  output logic                               cmd_valid_o,
  input  logic                               cmd_ready_i,
  output mws_pkg::cmd_t                      cmd_o
);

  localparam int unsigned CMP_W = mws_pkg::CMP_W;
  localparam int unsigned ROW_W = mws_pkg::ROW_W;
  localparam int unsigned COL_W = mws_pkg::COL_W;

  logic [mws_pkg::CFG_W-1:0] row_count_q, column_count_q, window_width_q, window_height_q;
  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] col_q, col_d;

  logic [CMP_W-1:0] rows, cols, win_w, win_h;
  logic [CMP_W-1:0] row_ext, col_ext, row_diff, col_diff;
  logic             last_col, last_row, accept;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q     <= mws_pkg::CFG_W'(2);
      column_count_q  <= mws_pkg::CFG_W'(2);
      window_width_q  <= mws_pkg::CFG_W'(1);
      window_height_q <= mws_pkg::CFG_W'(1);
    end else if (cfg_valid_i) begin
      unique case (mws_pkg::cfg_reg_e'(cfg_index_i))
        mws_pkg::CFG_ROW_COUNT:     row_count_q     <= cfg_data_i;
        mws_pkg::CFG_COLUMN_COUNT:  column_count_q  <= cfg_data_i;
        mws_pkg::CFG_WINDOW_WIDTH:  window_width_q  <= cfg_data_i;
        mws_pkg::CFG_WINDOW_HEIGHT: window_height_q <= cfg_data_i;
      endcase
    end
  end

  assign rows  = mws_pkg::clamp_count(row_count_q, mws_pkg::MAX_ROWS);
  assign cols  = mws_pkg::clamp_count(column_count_q, mws_pkg::MAX_COLUMNS);
  assign win_w = mws_pkg::window_size(window_width_q);
  assign win_h = mws_pkg::window_size(window_height_q);

  assign row_ext  = CMP_W'(row_q);
  assign col_ext  = CMP_W'(col_q);
  assign row_diff = row_ext - win_h;
  assign col_diff = col_ext - win_w;
  assign last_col = (col_ext + CMP_W'(1)) >= cols;
  assign last_row = (row_ext + CMP_W'(1)) >= rows;

  assign in_ready_o  = cmd_ready_i;
  assign cmd_valid_o = in_valid_i;
  assign accept      = in_valid_i && cmd_ready_i;

  always_comb begin
    cmd_o.element    = element_i;
    cmd_o.col        = col_q;
    cmd_o.line_waddr = {row_q, col_q};
    cmd_o.line_raddr = {row_diff[ROW_W-1:0], col_q};
    cmd_o.hist_raddr = col_diff[COL_W-1:0];
    cmd_o.first_row  = (row_q == '0);
    cmd_o.sub_line   = (row_ext >= win_h);
    cmd_o.col0       = (col_q == '0);
    cmd_o.sub_hist   = (col_ext >= win_w);
    cmd_o.win        = ((row_ext + CMP_W'(1)) >= win_h) && ((col_ext + CMP_W'(1)) >= win_w);
    cmd_o.last       = last_col && last_row;
  end

  // Columns advance along a row; the last column wraps to the next row or a new frame.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (!last_col) begin
        col_d = col_q + COL_W'(1);
      end else begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

endmodule

### sv/mws_fifo.sv
// Short command queue between the front end and the datapath.
// Depends on mws_pkg for the command type and the queue depth.
module mws_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  mws_pkg::cmd_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output mws_pkg::cmd_t pop_data_o
);

  localparam int unsigned PTR_W = mws_pkg::FIFO_PTR_W;
  localparam int unsigned CNT_W = PTR_W + 1;

  mws_pkg::cmd_t    slot_q [mws_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] count_q;
  logic             push, pop;

  assign push_ready_o = (count_q != CNT_W'(mws_pkg::FIFO_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = slot_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == PTR_W'(mws_pkg::FIFO_DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
      end
      if (pop) begin
        rptr_q <= (rptr_q == PTR_W'(mws_pkg::FIFO_DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count_q <= count_q + CNT_W'(1);
        2'b01:   count_q <= count_q - CNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

### sv/mws_back.sv
// Datapath: line store, column sums, row window sum and running maximum, with the
// result register. Depends on mws_pkg and on mws_ram for its three memories.
module mws_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cmd_valid_i,
  output logic                             cmd_ready_o,
  input  mws_pkg::cmd_t                    cmd_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [mws_pkg::SUM_W-1:0] max_sum_o,
  output logic                             no_window_o
);

  localparam int unsigned ELEM_W = mws_pkg::ELEM_W;
  localparam int unsigned CS_W   = mws_pkg::CS_W;
  localparam int unsigned ACC_W  = mws_pkg::ACC_W;
  localparam int unsigned SUM_W  = mws_pkg::SUM_W;

  logic pop, s2_fire, s3_fire;

  // Stage two: RAM data is present for the command held here.
  logic          s2_valid_q;
  mws_pkg::cmd_t s2_q;

  // Bypass of the write made by the command that left stage two as this one entered.
  logic                   fwd_col_hit_q, fwd_line_hit_q, fwd_hist_hit_q;
  logic signed [CS_W-1:0] fwd_cs_q;
  logic [ELEM_W-1:0]      fwd_elem_q;

  logic [CS_W-1:0]        col_rdata, hist_rdata;
  logic [ELEM_W-1:0]      line_rdata;
  logic signed [CS_W-1:0] cs_rd, hist_rd, cs_base, elem_ext, line_ext, cs_new;
  logic [ELEM_W-1:0]      line_rd;

  // Stage three: row window sum and maximum.
  logic                   s3_valid_q;
  logic signed [CS_W-1:0] s3_cs_q, s3_hist_q;
  logic                   s3_col0_q, s3_win_q, s3_last_q;

  logic signed [ACC_W-1:0] rws_q, rws_new, rws_base;
  logic signed [SUM_W-1:0] best_q, best_n, cand;
  logic                    found_q, found_n;

  logic                    out_valid_q, out_load;
  logic signed [SUM_W-1:0] max_sum_q;
  logic                    no_window_q;

  assign s3_fire     = s3_valid_q && !(s3_last_q && out_valid_q && !out_ready_i);
  assign s2_fire     = s2_valid_q && (!s3_valid_q || s3_fire);
  assign pop         = cmd_valid_i && (!s2_valid_q || s2_fire);
  assign cmd_ready_o = !s2_valid_q || s2_fire;

  mws_ram #(.WIDTH(CS_W), .DEPTH(mws_pkg::MAX_COLUMNS)) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (s2_fire),
    .waddr_i (s2_q.col),
    .wdata_i (cs_new),
    .re_i    (pop),
    .raddr_i (cmd_i.col),
    .rdata_o (col_rdata)
  );

  mws_ram #(.WIDTH(CS_W), .DEPTH(mws_pkg::MAX_COLUMNS)) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (s2_fire),
    .waddr_i (s2_q.col),
    .wdata_i (cs_new),
    .re_i    (pop),
    .raddr_i (cmd_i.hist_raddr),
    .rdata_o (hist_rdata)
  );

  mws_ram #(.WIDTH(ELEM_W), .DEPTH(mws_pkg::LINE_DEPTH)) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s2_fire),
    .waddr_i (s2_q.line_waddr),
    .wdata_i (s2_q.element),
    .re_i    (pop),
    .raddr_i (cmd_i.line_raddr),
    .rdata_o (line_rdata)
  );

  always_comb begin
    cs_rd    = fwd_col_hit_q  ? fwd_cs_q   : $signed(col_rdata);
    hist_rd  = fwd_hist_hit_q ? fwd_cs_q   : $signed(hist_rdata);
    line_rd  = fwd_line_hit_q ? fwd_elem_q : line_rdata;
    cs_base  = s2_q.first_row ? '0 : cs_rd;
    elem_ext = {{(CS_W-ELEM_W){s2_q.element[ELEM_W-1]}}, s2_q.element};
    line_ext = s2_q.sub_line ? {{(CS_W-ELEM_W){line_rd[ELEM_W-1]}}, line_rd} : '0;
    cs_new   = cs_base + elem_ext - line_ext;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q     <= 1'b0;
      fwd_col_hit_q  <= 1'b0;
      fwd_line_hit_q <= 1'b0;
      fwd_hist_hit_q <= 1'b0;
    end else begin
      if (pop) begin
        s2_valid_q     <= 1'b1;
        fwd_col_hit_q  <= s2_fire && (s2_q.col == cmd_i.col);
        fwd_line_hit_q <= s2_fire && (s2_q.line_waddr == cmd_i.line_raddr);
        fwd_hist_hit_q <= s2_fire && (s2_q.col == cmd_i.hist_raddr);
      end else if (s2_fire) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      s2_q       <= cmd_i;
      fwd_cs_q   <= cs_new;
      fwd_elem_q <= s2_q.element;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_fire) begin
      s3_cs_q   <= cs_new;
      s3_hist_q <= s2_q.sub_hist ? hist_rd : '0;
      s3_col0_q <= s2_q.col0;
      s3_win_q  <= s2_q.win;
      s3_last_q <= s2_q.last;
    end
  end

  always_comb begin
    rws_base = s3_col0_q ? '0 : rws_q;
    rws_new  = rws_base + ACC_W'(s3_cs_q) - ACC_W'(s3_hist_q);
    cand     = $signed(mws_pkg::sat_sum(rws_new));
    found_n  = found_q || s3_win_q;
    best_n   = best_q;
    if (s3_win_q && (!found_q || (cand > best_q))) begin
      best_n = cand;
    end
  end

  assign out_load = s3_fire && s3_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q  <= 1'b0;
      rws_q       <= '0;
      best_q      <= mws_pkg::SUM_MIN;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s2_fire) begin
        s3_valid_q <= 1'b1;
      end else if (s3_fire) begin
        s3_valid_q <= 1'b0;
      end
      if (s3_fire) begin
        rws_q <= rws_new;
        if (s3_last_q) begin
          best_q  <= mws_pkg::SUM_MIN;
          found_q <= 1'b0;
        end else begin
          best_q  <= best_n;
          found_q <= found_n;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      max_sum_q   <= found_n ? best_n : $signed(mws_pkg::SUM_MIN);
      no_window_q <= !found_n;
    end
  end

  assign out_valid_o = out_valid_q;
  assign max_sum_o   = max_sum_q;
  assign no_window_o = no_window_q;

endmodule

### sv/max_window_sum_2d.sv
// Top level of the maximum window sum block: front end, command queue and datapath.
// Depends on mws_pkg, mws_front, mws_fifo and mws_back.
//
// Elements of a frame are taken in row-major order at a sustained rate of one per
// clock cycle while no waiting result stalls the datapath; the column-sum memory
// has a write and a read port each cycle, and back-to-back reuse of the same
// column is bypassed from the previous write. After the last element of a frame
// one result (largest window sum and a no-window flag) is loaded into the output
// register once that element has passed the queue, stage two and stage three.
// Input keeps being taken while the result waits, until a further result has to
// wait behind it and the datapath and its four-entry queue are full. The line store
// and column sums need no clearing after reset. Configuration takes effect at the
// next element and should only be written while no element is still in flight.
module max_window_sum_2d (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [mws_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mws_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [mws_pkg::ELEM_W-1:0]  element_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [mws_pkg::SUM_W-1:0]   max_sum_o,
  output logic                               no_window_o
);

  logic          front_valid, front_ready;
  mws_pkg::cmd_t front_cmd;
  logic          back_valid, back_ready;
  mws_pkg::cmd_t back_cmd;

  mws_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .element_i   (element_i),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready),
    .cmd_o       (front_cmd)
  );

  mws_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  (front_cmd),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_data_o   (back_cmd)
  );

  mws_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (back_valid),
    .cmd_ready_o (back_ready),
    .cmd_i       (back_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .max_sum_o   (max_sum_o),
    .no_window_o (no_window_o)
  );

endmodule

### tb/tb.sv
// Self-checking testbench for max_window_sum_2d: streams matrix frames through the block,
// predicts the largest window sum of every frame and compares each result as it arrives.
// Depends on mws_pkg and the max_window_sum_2d RTL.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned SUM_W        = mws_pkg::SUM_W;
  localparam int unsigned CFG_W        = mws_pkg::CFG_W;
  localparam int unsigned CFG_IDX_W    = mws_pkg::CFG_IDX_W;
  localparam int unsigned ELEM_W       = mws_pkg::ELEM_W;
  localparam int unsigned MAX_ROWS     = mws_pkg::MAX_ROWS;
  localparam int unsigned MAX_COLUMNS  = mws_pkg::MAX_COLUMNS;

  localparam int unsigned RANDOM_ITEMS = 360;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam longint      SUM_HI       = 64'sd2147483647;
  localparam longint      SUM_LO       = -64'sd2147483648;

  typedef enum int unsigned {SENDER_IDLES, RECEIVER_IDLES, NO_IDLES} idle_mode_e;
  typedef enum int unsigned {ELEM_MIX, ELEM_ALL_MAX, ELEM_ALL_MIN, ELEM_ALTERNATE} elem_style_e;

  typedef struct {
    logic signed [SUM_W-1:0] max_sum;
    logic                    no_window;
  } frame_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i = '0;
  logic [CFG_W-1:0]         cfg_data_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic signed [ELEM_W-1:0] element_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [SUM_W-1:0]  max_sum_o;
  logic                     no_window_o;

  max_window_sum_2d dut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .element_i,
    .out_valid_o,
    .out_ready_i,
    .max_sum_o,
    .no_window_o
  );

  always #5 clk_i = ~clk_i;

  logic signed [ELEM_W-1:0] element_q[$];
  frame_result_t            expected_max_q[$];
  int unsigned              send_idle_pct = 27;
  int unsigned              recv_idle_pct = 65;
  logic                     in_fired = 1'b0;
  int unsigned              mismatch_count = 0;
  int unsigned              cycle_count = 0;

  // Predictor state: the registers as the block should hold them, and the frame progress.
  logic [CFG_W-1:0]         cfg_rows = 8'd2;
  logic [CFG_W-1:0]         cfg_cols = 8'd2;
  logic [CFG_W-1:0]         cfg_win_w = 8'd1;
  logic [CFG_W-1:0]         cfg_win_h = 8'd1;
  logic signed [ELEM_W-1:0] seen_line[MAX_ROWS*MAX_COLUMNS];
  longint                   col_acc[MAX_COLUMNS];
  longint                   band_sum = 0;
  longint                   best_sum = SUM_LO;
  int unsigned              row_at = 0;
  int unsigned              col_at = 0;
  bit                       have_window = 1'b0;

  function automatic int unsigned eff_count(input logic [CFG_W-1:0] v, input int unsigned lim);
    if (v == '0) begin
      return 1;
    end
    return (v > lim) ? lim : int'(v);
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  task automatic predict_window_max(input logic signed [ELEM_W-1:0] elem);
    int unsigned   rows;
    int unsigned   cols;
    int unsigned   w;
    int unsigned   h;
    int unsigned   r;
    int unsigned   c;
    longint        e;
    longint        cand;
    frame_result_t res;
    rows = eff_count(cfg_rows, MAX_ROWS);
    cols = eff_count(cfg_cols, MAX_COLUMNS);
    w    = (cfg_win_w == '0) ? 1 : int'(cfg_win_w);
    h    = (cfg_win_h == '0) ? 1 : int'(cfg_win_h);
    r    = row_at;
    c    = col_at;
    e    = elem;

    // Vertical sum over the last h rows; the oldest element leaves through the line store.
    if (r == 0) begin
      col_acc[c] = e;
    end else begin
      col_acc[c] += e;
    end
    if (r >= h) begin
      col_acc[c] -= seen_line[(r - h) * MAX_COLUMNS + c];
    end
    seen_line[r * MAX_COLUMNS + c] = elem;

    if (c == 0) begin
      band_sum = 0;
    end
    band_sum += col_acc[c];
    if (c >= w) begin
      band_sum -= col_acc[c - w];
    end

    if (r + 1 >= h && c + 1 >= w) begin
      cand = band_sum;
      if (cand > SUM_HI) begin
        cand = SUM_HI;
      end
      if (cand < SUM_LO) begin
        cand = SUM_LO;
      end
      if (!have_window || cand > best_sum) begin
        best_sum = cand;
      end
      have_window = 1'b1;
    end

    if (c + 1 < cols) begin
      col_at = c + 1;
    end else begin
      col_at = 0;
      if (r + 1 < rows) begin
        row_at = r + 1;
      end else begin
        res.max_sum   = have_window ? SUM_W'(best_sum) : SUM_W'(SUM_LO);
        res.no_window = !have_window;
        expected_max_q.push_back(res);
        band_sum    = 0;
        best_sum    = SUM_LO;
        row_at      = 0;
        have_window = 1'b0;
      end
    end
  endtask

  // Inputs change on the falling edge; a held element stays until its transfer.
  always @(negedge clk_i) begin : drive_inputs
    if (!in_valid_i || in_fired) begin
      if (element_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        element_i  <= element_q.pop_front();
      end else if (in_valid_i) begin
        in_valid_i <= 1'b0;
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin : watch_outputs
    frame_result_t want;
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      in_fired <= in_valid_i && in_ready_o;
      if (rst_ni) begin
        if (cfg_valid_i && cfg_ready_o) begin
          case (cfg_index_i)
            mws_pkg::CFG_ROW_COUNT:     cfg_rows  = cfg_data_i;
            mws_pkg::CFG_COLUMN_COUNT:  cfg_cols  = cfg_data_i;
            mws_pkg::CFG_WINDOW_WIDTH:  cfg_win_w = cfg_data_i;
            mws_pkg::CFG_WINDOW_HEIGHT: cfg_win_h = cfg_data_i;
            default: ;
          endcase
        end
        if (in_valid_i && in_ready_o) begin
          predict_window_max(element_i);
        end
        if (out_valid_o && out_ready_i) begin
          if (expected_max_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result max_sum=%0d no_window=%b",
                                      max_sum_o, no_window_o));
          end else begin
            want = expected_max_q.pop_front();
            if (max_sum_o !== want.max_sum) begin
              report_mismatch($sformatf("max_sum %0d, expected %0d", max_sum_o, want.max_sum));
            end
            if (no_window_o !== want.no_window) begin
              report_mismatch($sformatf("no_window %b, expected %b", no_window_o,
                                        want.no_window));
            end
          end
        end
      end
    end
  end

  // Waits until every element has had its transfer and every result has come out.
  task automatic wait_idle();
    do @(posedge clk_i); while (element_q.size() != 0 || in_valid_i);
    do @(negedge clk_i); while (expected_max_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Called on a falling edge; writes all four registers, starting at a random one.
  task automatic load_frame_regs(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols,
                                 input logic [CFG_W-1:0] win_w, input logic [CFG_W-1:0] win_h);
    mws_pkg::cfg_reg_e order[4];
    logic [CFG_W-1:0]  vals[4];
    int unsigned       first;
    int unsigned       k;
    order = '{mws_pkg::CFG_ROW_COUNT, mws_pkg::CFG_COLUMN_COUNT, mws_pkg::CFG_WINDOW_WIDTH,
              mws_pkg::CFG_WINDOW_HEIGHT};
    vals  = '{rows, cols, win_w, win_h};
    first = $urandom_range(3);
    for (int n = 0; n < 4; n++) begin
      k = (first + n) % 4;
      cfg_valid_i <= 1'b1;
      cfg_index_i <= order[k];
      cfg_data_i  <= vals[k];
      do @(posedge clk_i); while (!cfg_ready_o);
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic signed [ELEM_W-1:0] make_element(input elem_style_e style,
                                                            input int unsigned idx);
    case (style)
      ELEM_ALL_MAX:   return 16'sh7fff;
      ELEM_ALL_MIN:   return 16'sh8000;
      ELEM_ALTERNATE: return idx[0] ? 16'sh8000 : 16'sh7fff;
      default: begin
        case ($urandom_range(9))
          0:       return 16'sh7fff;
          1:       return 16'sh8000;
          2, 3, 4: return ELEM_W'($urandom_range(64) - 32);
          default: return ELEM_W'($urandom);
        endcase
      end
    endcase
  endfunction

  task automatic run_phase(input bit write_regs, input logic [CFG_W-1:0] rows,
                           input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] win_w,
                           input logic [CFG_W-1:0] win_h, input int unsigned frames,
                           input elem_style_e style, input idle_mode_e mode,
                           output int unsigned sent);
    sent = frames * eff_count(rows, MAX_ROWS) * eff_count(cols, MAX_COLUMNS);
    if (write_regs) begin
      load_frame_regs(rows, cols, win_w, win_h);
    end
    @(posedge clk_i);
    case (mode)
      SENDER_IDLES: begin
        send_idle_pct = 27;
        recv_idle_pct = 65;
      end
      RECEIVER_IDLES: begin
        send_idle_pct = 65;
        recv_idle_pct = 27;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
    for (int unsigned i = 0; i < sent; i++) begin
      element_q.push_back(make_element(style, i));
    end
    wait_idle();
  endtask

  initial begin : stimulus
    int unsigned      sent;
    int unsigned      random_sent;
    int unsigned      eff_cols;
    int unsigned      eff_rows;
    logic [CFG_W-1:0] rows;
    logic [CFG_W-1:0] cols;
    logic [CFG_W-1:0] win_w;
    logic [CFG_W-1:0] win_h;
    idle_mode_e       mode;
    random_sent = 0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed frames: reset settings, zero settings, windows that do not fit, all minimum.
    run_phase(1'b0, 8'd2, 8'd2, 8'd1, 8'd1, 1, ELEM_ALTERNATE, SENDER_IDLES, sent);
    run_phase(1'b1, 8'd0, 8'd0, 8'd0, 8'd0, 1, ELEM_ALL_MIN, SENDER_IDLES, sent);
    run_phase(1'b1, 8'd2, 8'd3, 8'd4, 8'd1, 1, ELEM_MIX, SENDER_IDLES, sent);
    run_phase(1'b1, 8'd1, 8'd2, 8'd1, 8'd2, 1, ELEM_MIX, SENDER_IDLES, sent);
    run_phase(1'b1, 8'd3, 8'd3, 8'd3, 8'd3, 1, ELEM_ALL_MIN, SENDER_IDLES, sent);

    // Full-size counts along one dimension at a time, including values above the limit.
    run_phase(1'b1, 8'd255, 8'd1, 8'd1, 8'd128, 1, ELEM_ALL_MAX, SENDER_IDLES, sent);
    run_phase(1'b1, 8'd1, 8'd128, 8'd128, 8'd1, 1, ELEM_ALL_MIN, SENDER_IDLES, sent);
    run_phase(1'b1, 8'd4, 8'd129, 8'd127, 8'd3, 1, ELEM_MIX, SENDER_IDLES, sent);

    while (random_sent < RANDOM_ITEMS) begin
      rows     = ($urandom_range(15) == 0) ? 8'd0 : CFG_W'($urandom_range(1, 6));
      cols     = ($urandom_range(15) == 0) ? 8'd0 : CFG_W'($urandom_range(1, 8));
      eff_rows = eff_count(rows, MAX_ROWS);
      eff_cols = eff_count(cols, MAX_COLUMNS);
      // Most windows fit; now and then one is made too wide or too tall.
      win_w = ($urandom_range(7) == 0) ? CFG_W'(eff_cols + $urandom_range(1, 3))
                                       : CFG_W'($urandom_range(eff_cols));
      win_h = ($urandom_range(7) == 0) ? CFG_W'(eff_rows + $urandom_range(1, 3))
                                       : CFG_W'($urandom_range(eff_rows));
      if (random_sent < RANDOM_ITEMS / 3) begin
        mode = SENDER_IDLES;
      end else if (random_sent < 2 * RANDOM_ITEMS / 3) begin
        mode = RECEIVER_IDLES;
      end else begin
        mode = NO_IDLES;
      end
      run_phase(1'b1, rows, cols, win_w, win_h, $urandom_range(1, 3), ELEM_MIX, mode, sent);
      random_sent += sent;
    end

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
